@@ hdl/biquad_tdf2_filter_macros.svh @@
// ---------------------------------------------------------------------------
// Biquad TDF-II assertion macros
// Shared property macros for the biquad section; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_TDF2_FILTER_MACROS_SVH
`define BIQUAD_TDF2_FILTER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define BQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("biquad assertion failed");

// Next-cycle implication, disabled during reset
`define BQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("biquad assertion failed");

`else

`define BQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/biq_pkg.sv @@
// ---------------------------------------------------------------------------
// Biquad package
// Types, codes and default widths shared by the biquad section modules.
// ---------------------------------------------------------------------------
package biq_pkg;

  // Default widths
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned COEF_BITS_DEF   = 32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_idx_e;

  // Request commands
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MB0,
    S_Y,
    S_D1A,
    S_D1B,
    S_D2A,
    S_D2B,
    S_CLR
  } state_e;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MS_B0,
    MS_B1,
    MS_A1,
    MS_B2,
    MS_A2
  } mul_sel_e;

  // Accumulator operations
  typedef enum logic [2:0] {
    AL_NONE,
    AL_Y,      // y = sat(floor((prod + z1) / 2^frac))
    AL_ADD_Z2, // acc = prod + z2
    AL_N1,     // z1 = sat(acc - prod)
    AL_LOAD,   // acc = prod
    AL_N2,     // z2 = sat(acc - prod), result out
    AL_CLEAR   // zero states, zero result
  } alu_op_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic     cap;
    logic     mul_en;
    mul_sel_e mul_sel;
    alu_op_e  alu_op;
    logic     out_load;
  } ctrl_t;

endpackage

@@ hdl/biquad_tdf2_filter.sv @@
// ---------------------------------------------------------------------------
// Biquad TDF-II filter section
// One second-order IIR section in transposed direct form II, fixed point.
// Input channel (in_valid_i/in_ready_o) takes one request: a sample to
// filter or a clear command, plus a block-end marker that is copied out.
// Output channel (out_valid_o/out_ready_i) returns one result per request.
// Five Q4.(COEF_BITS-4) coefficients are written through cfg_we_i; the user
// must write them only while the section is idle, which the block itself
// does not enforce. Writes to unknown indexes are dropped. A filter request
// steps through S_MB0, S_Y, S_D1A, S_D1B, S_D2A and S_D2B and loads its
// result in S_D2B; in_ready_o returns high in the cycle after the result is
// loaded, so a new request waits until the last has left the sequencer. The
// steps are set by the five products that share one registered multiplier,
// one product per cycle. A clear request loads its result in S_CLR.
// A result waits in the output register while the receiver stalls; the next
// request is accepted meanwhile and its last step holds until the register
// frees up. Reset zeroes both delay states, restores the default
// coefficients (b0 = 1.0, others 0) and drops any pending result.
// ---------------------------------------------------------------------------
`include "biquad_tdf2_filter_macros.svh"

module biquad_tdf2_filter
  import biq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COEF_BITS-1:0]          cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          block_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o,
  output logic                          block_end_out_o
);

  localparam int unsigned STATE_BITS = SAMPLE_BITS + COEF_BITS;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

  logic signed [COEF_BITS-1:0]   coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  ctrl_t                         ctrl;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_op;
  logic signed [STATE_BITS-1:0]  prod;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= COEF_ONE;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_B0:  coef_b0_q <= cfg_data_i;
        REG_B1:  coef_b1_q <= cfg_data_i;
        REG_B2:  coef_b2_q <= cfg_data_i;
        REG_A1:  coef_a1_q <= cfg_data_i;
        REG_A2:  coef_a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // Shared multiplier
  biq_mul #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .coef_i (mul_coef),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Datapath
  biq_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .sample_in_i     (sample_in_i),
    .block_end_i     (block_end_i),
    .coef_b0_i       (coef_b0_q),
    .coef_b1_i       (coef_b1_q),
    .coef_b2_i       (coef_b2_q),
    .coef_a1_i       (coef_a1_q),
    .coef_a2_i       (coef_a2_q),
    .mul_coef_o      (mul_coef),
    .mul_op_o        (mul_op),
    .prod_i          (prod),
    .sample_out_o    (sample_out_o),
    .clipped_o       (clipped_o),
    .block_end_out_o (block_end_out_o)
  );

  // Checks
  // an accepted request leaves the sequencer busy in the cycle after acceptance
  `BQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a new result appears exactly when the sequencer has gone back to idle
  `BQ_ASSERT_IMPL(a_idle_on_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)
  // a clear request that is not stalled yields a zero, unclipped result
  `BQ_ASSERT_NEXT(a_clear_result, clk_i, rst_ni, ctrl.alu_op == AL_CLEAR, out_valid_o && sample_out_o == '0 && !clipped_o)

endmodule

@@ hdl/biq_mul.sv @@
// ---------------------------------------------------------------------------
// Biquad shared multiplier
// Signed coefficient by sample multiply with a registered product.
// ---------------------------------------------------------------------------
module biq_mul
  import biq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [COEF_BITS-1:0]              coef_i,
  input  logic signed [SAMPLE_BITS-1:0]            op_i,
  output logic signed [SAMPLE_BITS+COEF_BITS-1:0]  prod_o
);

  localparam int unsigned STATE_BITS = SAMPLE_BITS + COEF_BITS;

  logic signed [STATE_BITS-1:0] prod_d, prod_q;

  // Full-precision product
  assign prod_d = coef_i * op_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/biq_dp.sv @@
// ---------------------------------------------------------------------------
// Biquad datapath
// Operand selection, accumulator, saturation, delay states and result
// register of the biquad section.
// ---------------------------------------------------------------------------
module biq_dp
  import biq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ctrl_t                                   ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_in_i,
  input  logic                                    block_end_i,
  input  logic signed [COEF_BITS-1:0]             coef_b0_i,
  input  logic signed [COEF_BITS-1:0]             coef_b1_i,
  input  logic signed [COEF_BITS-1:0]             coef_b2_i,
  input  logic signed [COEF_BITS-1:0]             coef_a1_i,
  input  logic signed [COEF_BITS-1:0]             coef_a2_i,
  output logic signed [COEF_BITS-1:0]             mul_coef_o,
  output logic signed [SAMPLE_BITS-1:0]           mul_op_o,
  input  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_i,
  output logic signed [SAMPLE_BITS-1:0]           sample_out_o,
  output logic                                    clipped_o,
  output logic                                    block_end_out_o
);

  localparam int unsigned STATE_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W      = STATE_BITS + 2;
  localparam int unsigned COEF_FRAC  = COEF_BITS - 4;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [STATE_BITS-1:0]  ST_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0]  ST_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_q, y_q, y_d;
  logic                          be_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [STATE_BITS-1:0]  z1_q, z1_d, z2_q, z2_d;
  logic                          clip_q, clip_d;
  logic signed [SAMPLE_BITS-1:0] out_smp_q, out_smp_d;
  logic                          out_clip_q, out_clip_d;
  logic                          out_be_q;

  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       sum_y, sh_y, sum_z2, diff;
  logic                          y_ovf, st_ovf;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [STATE_BITS-1:0]  st_sat;

  // Multiplier operand select
  always_comb begin
    unique case (ctrl_i.mul_sel)
      MS_B0:   mul_coef_o = coef_b0_i;
      MS_B1:   mul_coef_o = coef_b1_i;
      MS_A1:   mul_coef_o = coef_a1_i;
      MS_B2:   mul_coef_o = coef_b2_i;
      MS_A2:   mul_coef_o = coef_a2_i;
      default: mul_coef_o = coef_b0_i;
    endcase
    mul_op_o = ((ctrl_i.mul_sel == MS_A1) || (ctrl_i.mul_sel == MS_A2)) ? y_q : x_q;
  end

  // Output sample: add z1, arithmetic shift to sample format, clamp
  assign prod_ext = ACC_W'(prod_i);
  assign sum_y    = prod_ext + ACC_W'(z1_q);
  assign sh_y     = sum_y >>> COEF_FRAC;
  assign y_ovf    = !((&sh_y[ACC_W-1:SAMPLE_BITS-1]) || !(|sh_y[ACC_W-1:SAMPLE_BITS-1]));
  assign y_sat    = y_ovf ? (sh_y[ACC_W-1] ? SMP_MIN : SMP_MAX) : sh_y[SAMPLE_BITS-1:0];

  // State terms: partial sum with z2, subtract feedback, clamp
  assign sum_z2 = prod_ext + ACC_W'(z2_q);
  assign diff   = acc_q - prod_ext;
  assign st_ovf = !((&diff[ACC_W-1:STATE_BITS-1]) || !(|diff[ACC_W-1:STATE_BITS-1]));
  assign st_sat = st_ovf ? (diff[ACC_W-1] ? ST_MIN : ST_MAX) : diff[STATE_BITS-1:0];

  // Accumulator and state update
  always_comb begin
    y_d        = y_q;
    acc_d      = acc_q;
    z1_d       = z1_q;
    z2_d       = z2_q;
    clip_d     = ctrl_i.cap ? 1'b0 : clip_q;
    out_smp_d  = out_smp_q;
    out_clip_d = out_clip_q;
    unique case (ctrl_i.alu_op)
      AL_NONE: ;
      AL_Y: begin
        y_d    = y_sat;
        clip_d = clip_q | y_ovf;
      end
      AL_ADD_Z2: acc_d = sum_z2;
      AL_N1: begin
        z1_d   = st_sat;
        clip_d = clip_q | st_ovf;
      end
      AL_LOAD: acc_d = prod_ext;
      AL_N2: begin
        z2_d       = st_sat;
        out_smp_d  = y_q;
        out_clip_d = clip_q | st_ovf;
      end
      AL_CLEAR: begin
        z1_d       = '0;
        z2_d       = '0;
        out_smp_d  = '0;
        out_clip_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Delay states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
    end else begin
      z1_q <= z1_d;
      z2_q <= z2_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      x_q  <= sample_in_i;
      be_q <= block_end_i;
    end
    y_q        <= y_d;
    acc_q      <= acc_d;
    clip_q     <= clip_d;
    out_smp_q  <= out_smp_d;
    out_clip_q <= out_clip_d;
    if (ctrl_i.out_load) begin
      out_be_q <= be_q;
    end
  end

  assign sample_out_o    = out_smp_q;
  assign clipped_o       = out_clip_q;
  assign block_end_out_o = out_be_q;

endmodule

@@ hdl/biq_ctrl.sv @@
// ---------------------------------------------------------------------------
// Biquad sequencer
// Steps the shared multiplier and accumulator through one request and
// owns the input ready and result valid flags.
// ---------------------------------------------------------------------------
module biq_ctrl
  import biq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  command_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (command_i == CMD_CLEAR) ? S_CLR : S_MB0;
        end
      end
      S_MB0: state_d = S_Y;
      S_Y:   state_d = S_D1A;
      S_D1A: state_d = S_D1B;
      S_D1B: state_d = S_D2A;
      S_D2A: state_d = S_D2B;
      S_D2B: if (out_free) state_d = S_IDLE;
      S_CLR: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Step controls
  always_comb begin
    ctrl_o.cap      = 1'b0;
    ctrl_o.mul_en   = 1'b0;
    ctrl_o.mul_sel  = MS_B0;
    ctrl_o.alu_op   = AL_NONE;
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: ctrl_o.cap = accept;
      S_MB0: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_B0;
      end
      S_Y: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_B1;
        ctrl_o.alu_op  = AL_Y;
      end
      S_D1A: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_A1;
        ctrl_o.alu_op  = AL_ADD_Z2;
      end
      S_D1B: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_B2;
        ctrl_o.alu_op  = AL_N1;
      end
      S_D2A: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_A2;
        ctrl_o.alu_op  = AL_LOAD;
      end
      S_D2B: begin
        // hold here until the result register is free
        if (out_free) begin
          ctrl_o.alu_op   = AL_N2;
          ctrl_o.out_load = 1'b1;
        end
      end
      S_CLR: begin
        if (out_free) begin
          ctrl_o.alu_op   = AL_CLEAR;
          ctrl_o.out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Biquad TDF-II section testbench
// Drives filter and clear requests through the valid/ready channels,
// reprograms the five coefficients between phases while the section is
// idle, and compares every result against an in-bench fixed-point model of
// the transposed direct form II section, with saturating output and states.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import biq_pkg::*;

  localparam int unsigned SW   = SAMPLE_BITS_DEF;
  localparam int unsigned CW   = COEF_BITS_DEF;
  localparam int unsigned STW  = SW + CW;
  localparam int unsigned FRAC = CW - 4;

  localparam longint ONE_Q = longint'(1) << FRAC;

  localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  // First register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_A2 + 1'b1;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned ITEMS_PER_SET  = 77;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum int {
    SHAPE_LOWPASS,
    SHAPE_RESONANT,
    SHAPE_STABLE,
    SHAPE_WILD,
    SHAPE_RAILS,
    SHAPE_FIR,
    SHAPE_COUNT
  } coef_shape_e;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clipped;
    logic                 block_end;
  } filter_result_t;

  // DUT ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0]        cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 command_i   = CMD_FILTER;
  logic signed [SW-1:0] sample_in_i = '0;
  logic                 block_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] sample_out_o;
  logic                 clipped_o;
  logic                 block_end_out_o;

  // Model copy of the coefficients and the delay line
  logic signed [CW-1:0] b0_cfg = ONE_Q[CW-1:0];
  logic signed [CW-1:0] b1_cfg = '0;
  logic signed [CW-1:0] b2_cfg = '0;
  logic signed [CW-1:0] a1_cfg = '0;
  logic signed [CW-1:0] a2_cfg = '0;
  longint               z1_state = 0;
  longint               z2_state = 0;

  filter_result_t pending_results[$];
  int unsigned    fail_count     = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;

  biquad_tdf2_filter #(
    .SAMPLE_BITS(SW),
    .COEF_BITS  (CW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .sample_in_i    (sample_in_i),
    .block_end_i    (block_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .clipped_o      (clipped_o),
    .block_end_out_o(block_end_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clamp to a signed value of the given width, flag if it had to
  function automatic longint clamp_signed(longint v, int unsigned bits, inout bit clip);
    longint maxv;
    longint minv;
    maxv = (longint'(1) << (bits - 1)) - 1;
    minv = -maxv - 1;
    if (v > maxv) begin
      clip = 1'b1;
      return maxv;
    end
    if (v < minv) begin
      clip = 1'b1;
      return minv;
    end
    return v;
  endfunction

  // One step of the section; updates the model delay line.
  // Products and sums fit easily in 64 bits at these widths.
  function automatic filter_result_t filter_predict(logic cmd, logic signed [SW-1:0] x,
                                                    logic be);
    filter_result_t r;
    longint         y;
    longint         n1;
    longint         n2;
    bit             clip;
    r.block_end = be;
    if (cmd == CMD_CLEAR) begin
      z1_state  = 0;
      z2_state  = 0;
      r.sample  = '0;
      r.clipped = 1'b0;
      return r;
    end
    clip = 1'b0;
    y  = clamp_signed((longint'(b0_cfg) * longint'(x) + z1_state) >>> FRAC, SW, clip);
    n1 = clamp_signed(longint'(b1_cfg) * longint'(x) - longint'(a1_cfg) * y + z2_state,
                      STW, clip);
    n2 = clamp_signed(longint'(b2_cfg) * longint'(x) - longint'(a2_cfg) * y, STW, clip);
    z1_state  = n1;
    z2_state  = n2;
    r.sample  = y[SW-1:0];
    r.clipped = clip;
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Result checker and receiver stall generator
  always @(posedge clk_i) begin : result_monitor
    filter_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: sample %0d clipped %0b end %0b",
                               sample_out_o, clipped_o, block_end_out_o));
      end else begin
        want = pending_results.pop_front();
        if (want.sample !== sample_out_o || want.clipped !== clipped_o ||
            want.block_end !== block_end_out_o) begin
          note_failure($sformatf(
            "mismatch: expected sample %0d clipped %0b end %0b, got %0d %0b %0b",
            want.sample, want.clipped, want.block_end,
            sample_out_o, clipped_o, block_end_out_o));
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request; returns in the time step it was accepted
  task automatic send_request(logic cmd, logic signed [SW-1:0] x, logic be);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    sample_in_i <= x;
    block_end_i <= be;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(filter_predict(cmd, x, be));
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (index)
      REG_B0:  b0_cfg = value;
      REG_B1:  b1_cfg = value;
      REG_B2:  b2_cfg = value;
      REG_A1:  a1_cfg = value;
      REG_A2:  a2_cfg = value;
      default: ;
    endcase
  endtask

  // Reprogram all coefficients while idle, plus a write to an unused index
  task automatic apply_coefs(logic [CW-1:0] b0, logic [CW-1:0] b1, logic [CW-1:0] b2,
                             logic [CW-1:0] a1, logic [CW-1:0] a2);
    wait_for_results();
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, (1 << CFG_IDX_W) - 1)),
              $urandom());
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(3))
      0: s = SW'($urandom());
      1: s = SW'(int'($urandom_range(8191)) - 4096);
      2: s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: s = SW'(int'($urandom_range(2097151)) - 1048576);
    endcase
    return s;
  endfunction

  // Uniform signed value in [-span, span]
  function automatic logic [CW-1:0] pick_signed(longint span);
    longint v;
    v = longint'($urandom_range(32'(2 * span))) - span;
    return v[CW-1:0];
  endfunction

  task automatic load_shape(coef_shape_e shape);
    logic [CW-1:0] c[5];
    longint        a2v;
    longint        lim;
    case (shape)
      SHAPE_LOWPASS: begin
        // gentle low-pass, poles well inside the unit circle
        c[0] = 18119393;
        c[1] = 36238786;
        c[2] = 18119393;
        c[3] = -306821725;
        c[4] = 110810156;
      end
      SHAPE_RESONANT: begin
        // sharp peak near DC, drives the states toward their rails
        c[0] = ONE_Q[CW-1:0];
        c[1] = -510027366;
        c[2] = 255013683;
        c[3] = -531502203;
        c[4] = 265751101;
      end
      SHAPE_STABLE: begin
        a2v = $urandom_range(241591910);
        lim = ((ONE_Q + a2v) * 95) / 100;
        c[0] = pick_signed(ONE_Q);
        c[1] = pick_signed(ONE_Q);
        c[2] = pick_signed(ONE_Q);
        c[3] = pick_signed(lim);
        c[4] = a2v[CW-1:0];
      end
      SHAPE_WILD: begin
        foreach (c[i]) c[i] = $urandom();
      end
      SHAPE_RAILS: begin
        foreach (c[i]) c[i] = $urandom_range(1) ? COEF_MAX : COEF_MIN;
      end
      default: begin
        // FIR only
        c[0] = pick_signed(2 * ONE_Q);
        c[1] = pick_signed(2 * ONE_Q);
        c[2] = pick_signed(2 * ONE_Q);
        c[3] = '0;
        c[4] = '0;
      end
    endcase
    apply_coefs(c[0], c[1], c[2], c[3], c[4]);
  endtask

  // Reset coefficients give unity gain: output equals input
  task automatic test_default_passthrough();
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b0);
    send_request(CMD_FILTER, SAMPLE_MIN, 1'b1);
    send_request(CMD_FILTER, '0, 1'b0);
    send_request(CMD_FILTER, SW'(-1), 1'b1);
    send_request(CMD_FILTER, SW'(1), 1'b0);
    send_request(CMD_FILTER, {(SW/2){2'b01}}, 1'b0);
    send_request(CMD_FILTER, {(SW/2){2'b10}}, 1'b1);
    // clear ignores the sample but still carries the marker
    send_request(CMD_CLEAR, SW'($urandom()), 1'b1);
  endtask

  // Full-scale coefficients and samples: output and state saturation
  task automatic test_extreme_coefs();
    apply_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b0);
    send_request(CMD_FILTER, SAMPLE_MIN, 1'b0);
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b1);
    send_request(CMD_CLEAR, SAMPLE_MAX, 1'b0);
    apply_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b0);
    send_request(CMD_FILTER, SAMPLE_MIN, 1'b0);
    send_request(CMD_FILTER, SW'(1), 1'b1);
    send_request(CMD_CLEAR, SAMPLE_MIN, 1'b1);
    apply_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_request(CMD_FILTER, SAMPLE_MIN, 1'b0);
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b0);
    send_request(CMD_FILTER, '0, 1'b1);
    apply_coefs('0, '0, '0, '0, '0);
    send_request(CMD_FILTER, SAMPLE_MAX, 1'b1);
  endtask

  // Blocks of random samples under every idling mix and coefficient shape
  task automatic test_random_traffic();
    int unsigned send_mix[4] = '{0, 70, 0, 18};
    int unsigned recv_mix[4] = '{0, 0, 70, 18};
    int unsigned left;
    int unsigned blk_len;
    logic        cmd;
    logic        be;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < SHAPE_COUNT; s++) begin
        load_shape(coef_shape_e'(s));
        send_idle_pct  = send_mix[p];
        recv_stall_pct = recv_mix[p];
        left = ITEMS_PER_SET;
        while (left > 0) begin
          blk_len = $urandom_range(1, 16);
          for (int j = 0; j < blk_len && left > 0; j++) begin
            cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_FILTER;
            be  = (j == blk_len - 1);
            // occasional misplaced marker
            if ($urandom_range(99) < 5) be = ~be;
            send_request(cmd, pick_sample(), be);
            left--;
            if ($urandom_range(199) == 0) wait_for_results();
          end
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_passthrough();
    test_extreme_coefs();
    test_random_traffic();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
